@@ rtl/u8seg_pkg.sv @@
package u8seg_pkg;

  localparam logic [7:0]  LEAD2_LO   = 8'hC2;
  localparam logic [7:0]  LEAD2_HI   = 8'hDF;
  localparam logic [7:0]  LEAD3_LO   = 8'hE0;
  localparam logic [7:0]  LEAD3_HI   = 8'hEF;
  localparam logic [7:0]  LEAD4_LO   = 8'hF0;
  localparam logic [7:0]  LEAD4_HI   = 8'hF4;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [25:0] MIN_LEN2   = 26'h80;
  localparam logic [25:0] MIN_LEN3   = 26'h800;
  localparam logic [25:0] MIN_LEN4   = 26'h10000;
  localparam logic [25:0] SURR_LO    = 26'hD800;
  localparam logic [25:0] SURR_HI    = 26'hDFFF;
  localparam logic [25:0] SCALAR_MAX = 26'h10FFFF;
  localparam logic [7:0]  CPL_RESET  = 8'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } u8seg_in_t;

  typedef struct packed {
    logic [2:0]  unit_length;
    logic        scalar_ok;
    logic [20:0] scalar_value;
    logic        line_start;
    logic        message_done;
    logic        run_last;
  } u8seg_out_t;

  // one byte's worth of work: flushed held bytes, then an optional final unit
  typedef struct packed {
    logic [2:0][7:0] held;
    logic [1:0]      n_held;
    logic            fin_valid;
    logic [2:0]      fin_len;
    logic            fin_ok;
    logic [20:0]     fin_value;
    logic            msg_end;
  } u8seg_cmd_t;

endpackage

@@ rtl/u8seg_front.sv @@
module u8seg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  u8seg_pkg::u8seg_in_t byte_data,
  input  logic                 q_full,
  output logic                 push,
  output u8seg_pkg::u8seg_cmd_t cmd
);
  import u8seg_pkg::*;

  typedef struct packed {
    logic        emit;
    logic        ok;
    logic [2:0]  len;
    logic [20:0] bits;
  } lead_t;

  function automatic lead_t scan_lead(input logic [7:0] b, input logic last);
    lead_t r;
    r = '0;
    if (b < CONT_MARK) begin
      r.emit = 1'b1;
      r.ok   = 1'b1;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      r.len  = 3'd2;
      r.bits = {16'd0, b[4:0]};
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      r.len  = 3'd3;
      r.bits = {17'd0, b[3:0]};
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      r.len  = 3'd4;
      r.bits = {18'd0, b[2:0]};
    end
    if (!r.ok && (r.len == 3'd0 || last)) begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  logic [2:0][7:0] held_bytes, held_bytes_next;
  logic [1:0]      held_count, held_count_next;
  logic [2:0]      expected_length, expected_length_next;
  logic [20:0]     partial_scalar, partial_scalar_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        is_idle;
  logic        is_cont;
  logic        complete;
  logic        bad;
  logic [25:0] v;
  lead_t       lead;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign b          = byte_data.data_byte;
  assign last       = byte_data.message_end;
  assign is_idle    = (expected_length == 3'd0) || (held_count == 2'd0);
  assign is_cont    = (b & CONT_MASK) == CONT_MARK;
  assign v          = {partial_scalar[19:0], b[5:0]};
  assign complete   = ({1'b0, held_count} + 3'd1) >= expected_length;
  assign bad        = (expected_length == 3'd2 && v < MIN_LEN2) ||
                      (expected_length == 3'd3 && v < MIN_LEN3) ||
                      (expected_length == 3'd4 && v < MIN_LEN4) ||
                      (v >= SURR_LO && v <= SURR_HI) || (v > SCALAR_MAX);
  assign lead       = scan_lead(b, last);

  always_comb begin
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    partial_scalar_next  = partial_scalar;
    cmd                  = '0;
    cmd.held             = held_bytes;
    cmd.msg_end          = last;

    if (is_idle || !is_cont) begin
      // a broken sequence flushes what it holds, then the byte is a new lead
      if (!is_idle) begin
        cmd.n_held = held_count;
      end
      held_count_next      = 2'd0;
      expected_length_next = 3'd0;
      partial_scalar_next  = '0;
      if (lead.emit) begin
        cmd.fin_valid = 1'b1;
        cmd.fin_len   = 3'd1;
        cmd.fin_ok    = lead.ok;
        cmd.fin_value = {13'd0, b};
      end else begin
        held_bytes_next[0]   = b;
        held_count_next      = 2'd1;
        expected_length_next = lead.len;
        partial_scalar_next  = lead.bits;
      end
    end else if (complete && !bad) begin
      cmd.fin_valid        = 1'b1;
      cmd.fin_len          = expected_length;
      cmd.fin_ok           = 1'b1;
      cmd.fin_value        = v[20:0];
      held_count_next      = 2'd0;
      expected_length_next = 3'd0;
      partial_scalar_next  = '0;
    end else if (complete || last) begin
      cmd.n_held           = held_count;
      cmd.fin_valid        = 1'b1;
      cmd.fin_len          = 3'd1;
      cmd.fin_ok           = 1'b0;
      cmd.fin_value        = {13'd0, b};
      held_count_next      = 2'd0;
      expected_length_next = 3'd0;
      partial_scalar_next  = '0;
    end else begin
      if (held_count == 2'd1) begin
        held_bytes_next[1] = b;
      end else begin
        held_bytes_next[2] = b;
      end
      held_count_next     = held_count + 2'd1;
      partial_scalar_next = v[20:0];
    end
  end

  assign push = accept && (cmd.fin_valid || cmd.n_held != 2'd0);

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
      partial_scalar  <= '0;
    end else if (accept) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
      partial_scalar  <= partial_scalar_next;
    end
  end

endmodule

@@ rtl/u8seg_queue.sv @@
module u8seg_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8seg_pkg::u8seg_cmd_t push_data,
  input  logic                  pop,
  output u8seg_pkg::u8seg_cmd_t head,
  output logic                  full,
  output logic                  not_empty
);
  import u8seg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8seg_cmd_t     slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/u8seg_back.sv @@
module u8seg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            cells_per_line,
  input  logic                  q_valid,
  input  u8seg_pkg::u8seg_cmd_t q_head,
  output logic                  pop,
  output logic                  unit_valid,
  input  logic                  unit_stall,
  output u8seg_pkg::u8seg_out_t unit_data
);
  import u8seg_pkg::*;

  logic [1:0]  idx;
  logic [7:0]  cells_on_line;
  logic [7:0]  cells_on_line_next;
  logic [7:0]  limit;
  logic [2:0]  total;
  logic        is_last;
  logic        ls;
  logic        load;
  u8seg_out_t  unit;

  assign limit   = (cells_per_line == 8'd0) ? 8'd1 : cells_per_line;
  assign total   = {1'b0, q_head.n_held} + {2'b0, q_head.fin_valid};
  assign is_last = ({1'b0, idx} + 3'd1) == total;
  assign ls      = (cells_on_line == 8'd0) || (cells_on_line >= limit);
  assign load    = q_valid && (!unit_valid || !unit_stall);
  assign pop     = load && is_last;

  always_comb begin
    unit              = '0;
    unit.line_start   = ls;
    unit.run_last     = is_last;
    unit.message_done = is_last && q_head.msg_end;
    if ({1'b0, idx} < {1'b0, q_head.n_held}) begin
      unit.unit_length = 3'd1;
      unit.scalar_ok   = 1'b0;
      unique case (idx)
        2'd0:    unit.scalar_value = {13'd0, q_head.held[0]};
        2'd1:    unit.scalar_value = {13'd0, q_head.held[1]};
        default: unit.scalar_value = {13'd0, q_head.held[2]};
      endcase
    end else begin
      unit.unit_length  = q_head.fin_len;
      unit.scalar_ok    = q_head.fin_ok;
      unit.scalar_value = q_head.fin_value;
    end
  end

  always_comb begin
    if (is_last && q_head.msg_end) begin
      cells_on_line_next = 8'd0;
    end else if (ls) begin
      cells_on_line_next = 8'd1;
    end else begin
      cells_on_line_next = cells_on_line + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_data <= unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid    <= 1'b0;
      idx           <= 2'd0;
      cells_on_line <= 8'd0;
    end else if (load) begin
      unit_valid    <= 1'b1;
      cells_on_line <= cells_on_line_next;
      // advance within the command, or drop back for the next one
      idx           <= is_last ? 2'd0 : idx + 2'd1;
    end else if (unit_valid && !unit_stall) begin
      unit_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/utf8_scalar_segmenter_with_wrap_core.sv @@
// channel  | direction | valid      | stall      | beat
// ---------+-----------+------------+------------+-------------------------
// byte     | in        | byte_valid | byte_stall | byte_data (u8seg_in_t)
// unit     | out       | unit_valid | unit_stall | unit_data (u8seg_out_t)
// config   | in        | cfg_write  | -          | cfg_data (cells_per_line)
//
// One byte is taken per cycle unless the queue is full; each unit is registered
// into the output register from its command at the queue head. A byte that
// flushes a broken sequence yields up to four units, sent one a cycle unless
// unit_stall holds, so the byte side stalls once the command queue fills.
// Synchronous active-high reset clears the sequence state, the queue and the
// line counter; cells_per_line returns to 80.
module utf8_scalar_segmenter_with_wrap_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  u8seg_pkg::u8seg_in_t  byte_data,
  output logic                  unit_valid,
  input  logic                  unit_stall,
  output u8seg_pkg::u8seg_out_t unit_data,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_data
);
  import u8seg_pkg::*;

  logic [7:0] cpl;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  u8seg_cmd_t cmd;
  u8seg_cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpl <= CPL_RESET;
    end else if (cfg_write) begin
      cpl <= cfg_data;
    end
  end

  u8seg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd)
  );

  u8seg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  u8seg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cells_per_line (cpl),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .unit_valid     (unit_valid),
    .unit_stall     (unit_stall),
    .unit_data      (unit_data)
  );

endmodule

@@ sim/tb_utf8_scalar_segmenter_with_wrap_core.sv @@
`timescale 1ns / 100ps

module tb_utf8_scalar_segmenter_with_wrap_core;
  import u8seg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    u8seg_in_t  beat;
    bit         typed;
    u8seg_out_t unit;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  u8seg_in_t  byte_data = '0;
  logic       unit_valid;
  logic       unit_stall = 1'b0;
  u8seg_out_t unit_data;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = '0;

  int send_gap_pct = 12;
  int stall_pct = 87;
  int cycle_count = 0;
  int unit_errors = 0;

  // shadow of the segmenter state
  logic [7:0]  line_width = CPL_RESET;
  logic [7:0]  held_q [3];
  int          held_n = 0;
  int          seq_len = 0;
  logic [25:0] acc = '0;
  int          line_cells = 0;

  u8seg_out_t step_units [$];
  u8seg_out_t expected_units [$];
  dir_row_t   dir_rows [$];
  logic [7:0] msg_bytes [$];

  utf8_scalar_segmenter_with_wrap_core dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .unit_valid(unit_valid),
    .unit_stall(unit_stall),
    .unit_data (unit_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_scalar_segmenter_with_wrap_core verification failed");
      $finish;
    end
  end

  task automatic put_unit(input int len, input bit ok, input logic [20:0] val);
    int         lim;
    u8seg_out_t u;
    lim = (line_width == 0) ? 1 : int'(line_width);
    u = '0;
    u.unit_length = len[2:0];
    u.scalar_ok = ok;
    u.scalar_value = val;
    if (line_cells == 0 || line_cells >= lim) begin
      u.line_start = 1'b1;
      line_cells = 1;
    end else begin
      line_cells = line_cells + 1;
    end
    step_units.push_back(u);
  endtask

  task automatic clear_seq();
    held_n = 0;
    seq_len = 0;
    acc = '0;
  endtask

  task automatic flush_held();
    for (int i = 0; i < held_n; i++) put_unit(1, 1'b0, {13'd0, held_q[i]});
    clear_seq();
  endtask

  function automatic bit bad_value(input int len, input logic [25:0] v);
    return (len == 2 && v < MIN_LEN2) || (len == 3 && v < MIN_LEN3) ||
           (len == 4 && v < MIN_LEN4) || (v >= SURR_LO && v <= SURR_HI) ||
           v > SCALAR_MAX;
  endfunction

  task automatic scan_lead(input logic [7:0] b, input bit last);
    int          len;
    logic [25:0] bits;
    len = 0;
    bits = '0;
    if (b < CONT_MARK) begin
      put_unit(1, 1'b1, {13'd0, b});
    end else begin
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        len = 2;
        bits = {21'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        len = 3;
        bits = {22'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        len = 4;
        bits = {23'd0, b[2:0]};
      end
      if (len == 0 || last) begin
        put_unit(1, 1'b0, {13'd0, b});
      end else begin
        held_q[0] = b;
        held_n = 1;
        seq_len = len;
        acc = bits;
      end
    end
  endtask

  // compute the units one input byte releases into step_units
  task automatic segment_byte(input u8seg_in_t d);
    logic [7:0]  b;
    bit          last;
    logic [25:0] v;
    u8seg_out_t  tail;
    b = d.data_byte;
    last = d.message_end;
    step_units.delete();
    if (seq_len == 0 || held_n == 0 || held_n > 3) begin
      clear_seq();
      scan_lead(b, last);
    end else if ((b & CONT_MASK) == CONT_MARK) begin
      v = {acc[19:0], b[5:0]};
      if (held_n + 1 >= seq_len) begin
        if (bad_value(seq_len, v)) begin
          flush_held();
          put_unit(1, 1'b0, {13'd0, b});
        end else begin
          put_unit(seq_len, 1'b1, v[20:0]);
          clear_seq();
        end
      end else if (last) begin
        flush_held();
        put_unit(1, 1'b0, {13'd0, b});
      end else begin
        held_q[held_n] = b;
        held_n++;
        acc = v & 26'h1FFFFF;
      end
    end else begin
      flush_held();
      scan_lead(b, last);
    end
    if (step_units.size() > 0) begin
      tail = step_units[step_units.size() - 1];
      tail.run_last = 1'b1;
      tail.message_done = last;
      step_units[step_units.size() - 1] = tail;
    end
    if (last) line_cells = 0;
  endtask

  task automatic send_byte(input u8seg_in_t d, input bit typed, input u8seg_out_t tu);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= d;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    segment_byte(d);
    if (typed) expected_units.push_back(tu);
    else foreach (step_units[i]) expected_units.push_back(step_units[i]);
  endtask

  // drop valid, let every expected unit drain, then let the pipe settle
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [7:0] w);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    line_width = w;
    cfg_write <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input bit e, input bit typed,
                         input bit ok, input bit ls, input bit done);
    dir_row_t r;
    r.beat.data_byte = b;
    r.beat.message_end = e;
    r.typed = typed;
    r.unit = '0;
    r.unit.unit_length = 3'd1;
    r.unit.scalar_ok = ok;
    r.unit.scalar_value = {13'd0, b};
    r.unit.line_start = ls;
    r.unit.message_done = done;
    r.unit.run_last = 1'b1;
    dir_rows.push_back(r);
  endtask

  task automatic push_encoded(input int len, input logic [20:0] v);
    case (len)
      1: msg_bytes.push_back(v[7:0]);
      2: begin
        msg_bytes.push_back({3'b110, v[10:6]});
        msg_bytes.push_back({2'b10, v[5:0]});
      end
      3: begin
        msg_bytes.push_back({4'b1110, v[15:12]});
        msg_bytes.push_back({2'b10, v[11:6]});
        msg_bytes.push_back({2'b10, v[5:0]});
      end
      default: begin
        msg_bytes.push_back({5'b11110, v[20:18]});
        msg_bytes.push_back({2'b10, v[17:12]});
        msg_bytes.push_back({2'b10, v[11:6]});
        msg_bytes.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] rand_scalar(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // one unit's worth of bytes: mostly well formed, some rejected, broken or noise
  task automatic add_piece();
    int k;
    int len;
    int cut;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      push_encoded(1, rand_scalar(1));
    end else if (k < 55) begin
      push_encoded(2, rand_scalar(2));
    end else if (k < 70) begin
      push_encoded(3, rand_scalar(3));
    end else if (k < 80) begin
      push_encoded(4, rand_scalar(4));
    end else if (k < 86) begin
      case ($urandom_range(0, 4))
        0: push_encoded(2, 21'($urandom_range(0, 'h7F)));
        1: push_encoded(3, 21'($urandom_range(0, 'h7FF)));
        2: push_encoded(4, 21'($urandom_range(0, 'hFFFF)));
        3: push_encoded(3, 21'($urandom_range('hD800, 'hDFFF)));
        default: push_encoded(4, 21'($urandom_range('h110000, 'h13FFFF)));
      endcase
    end else if (k < 93) begin
      len = $urandom_range(2, 4);
      cut = $urandom_range(1, len - 1);
      push_encoded(len, rand_scalar(len));
      repeat (len - cut) void'(msg_bytes.pop_back());
      msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_messages(input int n_bytes);
    int        sent;
    int        n_units;
    u8seg_in_t d;
    sent = 0;
    while (sent < n_bytes) begin
      n_units = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      msg_bytes.delete();
      repeat (n_units) add_piece();
      // hold the byte budget; a cut sequence ends as a truncated message
      while (msg_bytes.size() > n_bytes - sent) void'(msg_bytes.pop_back());
      foreach (msg_bytes[i]) begin
        d.data_byte = msg_bytes[i];
        d.message_end = (i == msg_bytes.size() - 1);
        send_byte(d, 1'b0, '0);
      end
      sent += msg_bytes.size();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && unit_valid && !unit_stall) check_unit(unit_data);
    unit_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic check_unit(input u8seg_out_t got);
    u8seg_out_t want;
    if (expected_units.size() == 0) begin
      unit_errors++;
      if (unit_errors <= 10)
        $display("unexpected unit: len=%0d ok=%0d val=%h ls=%0d done=%0d last=%0d",
                 got.unit_length, got.scalar_ok, got.scalar_value, got.line_start,
                 got.message_done, got.run_last);
    end else begin
      want = expected_units.pop_front();
      if (got.unit_length !== want.unit_length || got.scalar_ok !== want.scalar_ok ||
          got.scalar_value !== want.scalar_value || got.line_start !== want.line_start ||
          got.message_done !== want.message_done || got.run_last !== want.run_last) begin
        unit_errors++;
        if (unit_errors <= 10)
          $display("unit mismatch: exp len=%0d ok=%0d val=%h ls=%0d done=%0d last=%0d %s",
                   want.unit_length, want.scalar_ok, want.scalar_value, want.line_start,
                   want.message_done, want.run_last,
                   $sformatf("got len=%0d ok=%0d val=%h ls=%0d done=%0d last=%0d",
                             got.unit_length, got.scalar_ok, got.scalar_value,
                             got.line_start, got.message_done, got.run_last));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single-byte units with outcomes known up front
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(8'hC1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    // smallest two-byte, largest three- and four-byte scalars
    add_row(8'hC2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hEF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hF4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h8F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // overlong three-byte form, rejected once complete
    add_row(8'hE0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // above the scalar range
    add_row(8'hF4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h90, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // broken by a plain byte that is scanned again
    add_row(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // truncated by the end of the message, then a lone lead as a whole message
    add_row(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'h82, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(8'hC3, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);

    foreach (dir_rows[i]) send_byte(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].unit);

    set_line_width(8'd1);
    run_messages(48);
    set_line_width(8'd255);
    run_messages(48);

    send_gap_pct = 87;
    stall_pct = 12;
    set_line_width(8'd0);
    run_messages(48);
    set_line_width(8'd7);
    run_messages(48);

    send_gap_pct = 0;
    stall_pct = 0;
    set_line_width(8'd3);
    run_messages(48);
    set_line_width(8'd40);
    run_messages(48);

    wait_idle();
    if (unit_errors == 0 && expected_units.size() == 0) begin
      $display("utf8_scalar_segmenter_with_wrap_core verification clean");
    end else begin
      $display("utf8_scalar_segmenter_with_wrap_core verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/u8seg_pkg.sv
rtl/u8seg_front.sv
rtl/u8seg_queue.sv
rtl/u8seg_back.sv
rtl/utf8_scalar_segmenter_with_wrap_core.sv
sim/tb_utf8_scalar_segmenter_with_wrap_core.sv
